[sv/gh_pkg.sv]
// ----------------------------------------------------------------------------
// gh_pkg
// shared widths, request codes and register indexes of the ghash accumulator
// ----------------------------------------------------------------------------
package gh_pkg;

	localparam int WORD_W   = 64;
	localparam int BLOCK_W  = 128;
	localparam int NBYTES   = 16;
	localparam int VBYTES_W = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic REQ_ABSORB = 1'b0;
	localparam logic REQ_LOAD   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SUBKEY_HIGH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBKEY_LOW  = 1'b1;

	typedef logic [BLOCK_W-1:0] block_t;

endpackage

[sv/gh_if.sv]
// ----------------------------------------------------------------------------
// gh_in_if / gh_out_if
// valid/ready channels for request items and accumulator result items
// ----------------------------------------------------------------------------
interface gh_in_if;
	import gh_pkg::*;

	logic                valid;
	logic                ready;
	logic                req_type;
	logic [WORD_W-1:0]   block_high;
	logic [WORD_W-1:0]   block_low;
	logic [VBYTES_W-1:0] valid_bytes;

	modport source (output valid, req_type, block_high, block_low, valid_bytes, input ready);
	modport sink   (input valid, req_type, block_high, block_low, valid_bytes, output ready);
endinterface

interface gh_out_if;
	import gh_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] acc_high;
	logic [WORD_W-1:0] acc_low;

	modport source (output valid, acc_high, acc_low, input ready);
	modport sink   (input valid, acc_high, acc_low, output ready);
endinterface

[sv/gh_gfmul.sv]
// ----------------------------------------------------------------------------
// gh_gfmul
// combinational GF(2^128) multiplier, GCM polynomial, reflected bit order
// ----------------------------------------------------------------------------
module gh_gfmul (
	input  gh_pkg::block_t x,
	input  gh_pkg::block_t h,
	output gh_pkg::block_t z
);
	import gh_pkg::*;

	logic [BLOCK_W-1:0]     a;
	logic [BLOCK_W-1:0]     b;
	logic [2*BLOCK_W-2:0]   prod;
	logic [BLOCK_W+6:0]     fold;
	logic [BLOCK_W-1:0]     red;

	// coefficient of x^k sits at bit 127-k of the word
	always_comb begin
		for (int i = 0; i < BLOCK_W; i++) begin
			a[i] = x[BLOCK_W-1-i];
			b[i] = h[BLOCK_W-1-i];
		end
	end

	// carry-less product
	always_comb begin
		prod = '0;
		for (int i = 0; i < BLOCK_W; i++) begin
			for (int j = 0; j < BLOCK_W; j++) begin
				prod[i+j] = prod[i+j] ^ (a[i] & b[j]);
			end
		end
	end

	// reduce by x^128 = x^7 + x^2 + x + 1, two folds
	always_comb begin
		fold = {7'b0, prod[BLOCK_W-1:0]};
		for (int k = BLOCK_W; k < 2*BLOCK_W-1; k++) begin
			fold[k-128] = fold[k-128] ^ prod[k];
			fold[k-127] = fold[k-127] ^ prod[k];
			fold[k-126] = fold[k-126] ^ prod[k];
			fold[k-121] = fold[k-121] ^ prod[k];
		end
		red = fold[BLOCK_W-1:0];
		for (int k = BLOCK_W; k < BLOCK_W+7; k++) begin
			red[k-128] = red[k-128] ^ fold[k];
			red[k-127] = red[k-127] ^ fold[k];
			red[k-126] = red[k-126] ^ fold[k];
			red[k-121] = red[k-121] ^ fold[k];
		end
	end

	always_comb begin
		for (int m = 0; m < BLOCK_W; m++) begin
			z[BLOCK_W-1-m] = red[m];
		end
	end

endmodule

[sv/ghash_accumulator.sv]
// ----------------------------------------------------------------------------
// ghash_accumulator
// GCM GHASH multiply-accumulate with byte-masked absorb and direct load
// ----------------------------------------------------------------------------
// One request item is accepted every clock cycle unless an unread result
// stalls the full input register. Each item is captured in that register and
// moves on once the output is free: an absorb XORs its masked block into the
// accumulator, which a combinational GF(2^128) multiplier multiplies by H; a
// load replaces it. The accumulator is the result item; its feedback through
// the multiplier sets the one-item-per-cycle rate. While a result waits, one
// more item enters the input register. The user must write H through the
// configuration port only while no item is in flight; it is not enforced.
module ghash_accumulator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gh_pkg::WORD_W-1:0]      cfg_data,
	gh_in_if.sink                          din,
	gh_out_if.source                       dout
);
	import gh_pkg::*;

	logic                vld_s1;
	logic                req_s1;
	block_t              blk_s1;
	logic [VBYTES_W-1:0] nbytes_s1;

	block_t h_q;
	block_t acc_q;
	logic   out_vld_q;

	logic   adv;
	logic   in_acc;
	block_t mask;
	block_t mul_x;
	block_t mul_z;

	assign adv       = vld_s1 && (!out_vld_q || dout.ready);
	assign din.ready = !vld_s1 || adv;
	assign in_acc    = din.valid && din.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (din.ready) begin
			vld_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1    <= din.req_type;
			blk_s1    <= {din.block_high, din.block_low};
			nbytes_s1 <= din.valid_bytes;
		end
	end

	// subkey registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SUBKEY_HIGH: h_q[BLOCK_W-1:WORD_W] <= cfg_data;
				CFG_SUBKEY_LOW:  h_q[WORD_W-1:0]       <= cfg_data;
				default: ;
			endcase
		end
	end

	// keep the leading bytes only
	always_comb begin
		for (int i = 0; i < NBYTES; i++) begin
			mask[BLOCK_W-1-8*i -: 8] = (VBYTES_W'(i) < nbytes_s1) ? 8'hff : 8'h00;
		end
	end

	assign mul_x = acc_q ^ (blk_s1 & mask);

	gh_gfmul u_mul (
		.x (mul_x),
		.h (h_q),
		.z (mul_z)
	);

	// accumulator doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				if (req_s1 == REQ_LOAD) begin
					acc_q <= blk_s1;
				end else if (nbytes_s1 != '0) begin
					acc_q <= mul_z;
				end
				out_vld_q <= 1'b1;
			end else if (dout.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign dout.valid    = out_vld_q;
	assign dout.acc_high = acc_q[BLOCK_W-1:WORD_W];
	assign dout.acc_low  = acc_q[WORD_W-1:0];

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(acc_q))
		else $error("accumulator changed without an item");

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_vld_q)
		else $error("finished item not presented");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && req_s1 == REQ_LOAD) |=> (acc_q == $past(blk_s1)))
		else $error("load item not taken into accumulator");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> (vld_s1 && out_vld_q && !dout.ready))
		else $error("input stalled without a waiting result");

endmodule
